FILE: sv/greedy_box_suppression_unit_macros.svh
// Assertion macros for the greedy box suppression unit.
// Included by the top level; depends on nothing else.
`ifndef GREEDY_BOX_SUPPRESSION_UNIT_MACROS_SVH
`define GREEDY_BOX_SUPPRESSION_UNIT_MACROS_SVH

`define GBS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define GBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gbs_pkg.sv
// Package for the greedy box suppression unit: types, constants, states.
// Depends on nothing.
`default_nettype none
package gbs_pkg;
  localparam int MaxKeptDefault = 64;
  localparam logic [8:0] IouThresholdReset = 9'd115;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
  } box_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_MUL,
    ST_TEST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_issue;
    logic cmp;
    logic mul;
    logic test;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic out_busy;
  } status_t;
endpackage
`default_nettype wire

FILE: sv/gbs_ram.sv
// Generic single-port-write, registered-read RAM.
// Depends on nothing.
`default_nettype none
module gbs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/gbs_ctrl.sv
// Controller state machine for the greedy box suppression unit.
// Depends on gbs_pkg.
`default_nettype none
module gbs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire gbs_pkg::status_t status,
  output logic                 in_stall,
  output gbs_pkg::cmd_t        cmd
);
  gbs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gbs_pkg::ST_IDLE: if (in_valid) state_next = gbs_pkg::ST_READ;
      gbs_pkg::ST_READ: state_next = status.more ? gbs_pkg::ST_CMP : gbs_pkg::ST_DONE;
      gbs_pkg::ST_CMP:  state_next = gbs_pkg::ST_MUL;
      gbs_pkg::ST_MUL:  state_next = gbs_pkg::ST_TEST;
      gbs_pkg::ST_TEST: state_next = status.more ? gbs_pkg::ST_CMP : gbs_pkg::ST_DONE;
      gbs_pkg::ST_DONE: if (!status.out_busy) state_next = gbs_pkg::ST_IDLE;
      default:          state_next = gbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      gbs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      gbs_pkg::ST_READ: cmd.rd_issue = 1'b1;
      gbs_pkg::ST_CMP: cmd.cmp = 1'b1;
      gbs_pkg::ST_MUL: cmd.mul = 1'b1;
      gbs_pkg::ST_TEST: begin
        cmd.test = 1'b1;
        cmd.rd_issue = 1'b1;
      end
      gbs_pkg::ST_DONE: cmd.finish = !status.out_busy;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: sv/gbs_datapath.sv
// Datapath: kept-box memory, overlap unit, counters and output register.
// Depends on gbs_pkg and gbs_ram.
`default_nettype none
module gbs_datapath #(
  parameter int MaxKept = gbs_pkg::MaxKeptDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire gbs_pkg::cmd_t      cmd,
  output gbs_pkg::status_t        status,
  input  wire logic               frame_start,
  input  wire logic signed [15:0] box_x,
  input  wire logic signed [15:0] box_y,
  input  wire logic [14:0]        box_width,
  input  wire logic [14:0]        box_height,
  input  wire logic [8:0]         threshold,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    keep,
  output logic [15:0]             item_index,
  output logic [6:0]              kept_count,
  output logic                    list_full
);
  localparam int AW = (MaxKept > 1) ? $clog2(MaxKept) : 1;
  localparam int CW = $clog2(MaxKept + 1);

  gbs_pkg::box_t cur, rbox;
  logic [CW-1:0] total, scan;
  logic [15:0] pos;
  logic alive;
  logic [16:0] iw, ih;
  logic [31:0] area_c, area_r;
  logic [33:0] inter_prod;
  logic [33:0] inter;
  logic [34:0] uni;
  logic we;

  function automatic logic [16:0] ov(input logic signed [15:0] a0, input logic [14:0] al,
                                     input logic signed [15:0] b0, input logic [14:0] bl);
    logic signed [17:0] lo, hi, ea, eb;
    lo = (a0 > b0) ? 18'(a0) : 18'(b0);
    ea = 18'(a0) + 18'(signed'({1'b0, al}));
    eb = 18'(b0) + 18'(signed'({1'b0, bl}));
    hi = (ea < eb) ? ea : eb;
    return (hi > lo) ? 17'(hi - lo) : 17'd0;
  endfunction

  assign we = cmd.finish && alive && (total < CW'(MaxKept));

  gbs_ram #(.Width($bits(gbs_pkg::box_t)), .Depth(MaxKept)) u_ram (
    .clk(clk), .we(we), .waddr(total[AW-1:0]), .wdata(cur),
    .raddr(scan[AW-1:0]), .rdata(rbox)
  );

  assign status = '{more: alive && (scan < total), out_busy: out_valid && out_stall};

  assign inter_prod = 34'(iw) * 34'(ih);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= '{x: box_x, y: box_y, w: box_width, h: box_height};
    end
    if (cmd.cmp) begin
      iw <= ov(cur.x, cur.w, rbox.x, rbox.w);
      ih <= ov(cur.y, cur.h, rbox.y, rbox.h);
      area_c <= 32'(cur.w) * 32'(cur.h);
      area_r <= 32'(rbox.w) * 32'(rbox.h);
    end
    if (cmd.mul) begin
      inter <= inter_prod;
      uni <= 35'(area_c) + 35'(area_r) - 35'(inter_prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      pos <= '0;
      scan <= '0;
      alive <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish || (out_valid && out_stall);
      if (cmd.load) begin
        alive <= 1'b1;
        scan <= '0;
        if (frame_start) begin
          total <= '0;
          pos <= '0;
        end
      end
      if (cmd.rd_issue) scan <= scan + 1'b1;
      if (cmd.test && uni != '0 &&
          (44'({inter, 8'd0}) > 44'(threshold) * 44'(uni))) begin
        alive <= 1'b0;
      end
      if (cmd.finish) begin
        keep <= alive;
        item_index <= pos;
        pos <= pos + 16'd1;
        list_full <= alive && (total >= CW'(MaxKept));
        if (we) begin
          total <= total + 1'b1;
          kept_count <= 7'(total + 1'b1);
        end else begin
          kept_count <= 7'(total);
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: sv/greedy_box_suppression_unit.sv
// Greedy non-maximum suppression over boxes sorted by descending score.
// Requests enter on in_valid/in_stall; one result per request leaves on
// out_valid/out_stall. A request with frame_start set empties the kept list.
// Each request is compared against the stored boxes, one after another,
// by one overlap unit. After a first memory read, its steps per stored box
// are: the intersection spans and the areas, then the intersection product
// and the union, then the ratio test together with the memory read of the
// next stored box. At most MaxKept boxes are stored. A request finishes
// early when a stored box already suppresses it. The result is held in an
// output register until taken. The next request is accepted while a
// result waits, but the unit then holds in its last step until out_stall
// drops. The threshold is written through cfg_we/cfg_data while idle;
// the user is bound to this, and the block itself does not enforce it.
// Synchronous reset empties the list, zeros the frame position and sets
// the threshold to 115. Stored boxes live in a RAM that needs no
// clearing; only entries below the count are read.
// Depends on gbs_pkg, gbs_ctrl, gbs_datapath, gbs_ram and the macro header.
`default_nettype none
`include "greedy_box_suppression_unit_macros.svh"
module greedy_box_suppression_unit #(
  parameter int MaxKept = gbs_pkg::MaxKeptDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [8:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               frame_start,
  input  wire logic signed [15:0] box_x,
  input  wire logic signed [15:0] box_y,
  input  wire logic [14:0]        box_width,
  input  wire logic [14:0]        box_height,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    keep,
  output logic [15:0]             item_index,
  output logic [6:0]              kept_count,
  output logic                    list_full
);
  gbs_pkg::cmd_t cmd;
  gbs_pkg::status_t status;
  logic [8:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= gbs_pkg::IouThresholdReset;
    end else if (cfg_we) begin
      threshold <= cfg_data;
    end
  end

  gbs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .status(status),
    .in_stall(in_stall), .cmd(cmd)
  );

  gbs_datapath #(.MaxKept(MaxKept)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .frame_start(frame_start), .box_x(box_x), .box_y(box_y),
    .box_width(box_width), .box_height(box_height), .threshold(threshold),
    .out_valid(out_valid), .out_stall(out_stall), .keep(keep),
    .item_index(item_index), .kept_count(kept_count), .list_full(list_full)
  );

  `GBS_ASSERT_IMP(a_full_kept, clk, rst, out_valid && list_full, keep, "full without keep")
  `GBS_ASSERT_IMP(a_count_max, clk, rst, out_valid, kept_count <= 7'(MaxKept), "count too high")
  `GBS_ASSERT_NEXT(a_one_load, clk, rst, cmd.load, in_stall, "second accept too soon")
endmodule
`default_nettype wire

FILE: tb/sv/tb_greedy_box_suppression_unit.sv
// Self-checking testbench for the greedy box suppression unit.
// Drives boxes with random idle and stall, predicts every result with an
// IoU suppression predictor. Depends on gbs_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb_greedy_box_suppression_unit;
  localparam int MaxKept = gbs_pkg::MaxKeptDefault;
  localparam int NumRandom = 1000;

  typedef struct packed {
    logic        fs;
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
  } req_t;

  typedef struct packed {
    logic        keep;
    logic [15:0] idx;
    logic [6:0]  cnt;
    logic        full;
  } res_t;

  typedef struct {
    req_t       r;
    logic       has_res;
    res_t       res;
  } row_t;

  logic clk, rst;
  logic cfg_we;
  logic [8:0] cfg_data;
  logic in_valid, in_stall;
  logic frame_start;
  logic signed [15:0] box_x, box_y;
  logic [14:0] box_width, box_height;
  logic out_valid, out_stall;
  logic keep;
  logic [15:0] item_index;
  logic [6:0] kept_count;
  logic list_full;

  greedy_box_suppression_unit i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .frame_start(frame_start),
    .box_x(box_x), .box_y(box_y), .box_width(box_width), .box_height(box_height),
    .out_valid(out_valid), .out_stall(out_stall), .keep(keep),
    .item_index(item_index), .kept_count(kept_count), .list_full(list_full)
  );

  gbs_pkg::box_t kept_list[MaxKept];
  int         kept_num;
  logic [15:0] frame_pos;
  logic [8:0] threshold;
  res_t       pending_results[$];
  int         errors;
  int         accepted;
  int         kept_seen;
  int         full_seen;
  int         send_idle_pct;
  int         recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("** greedy_box_suppression_unit: FAILED **");
    $finish;
  end

  function automatic longint span_overlap(longint a0, longint alen, longint b0,
                                          longint blen);
    longint lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = ((a0 + alen) < (b0 + blen)) ? (a0 + alen) : (b0 + blen);
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function automatic bit overlaps_too_much(gbs_pkg::box_t a, gbs_pkg::box_t b);
    longint iw, ih, inter, uni;
    iw = span_overlap(a.x, a.w, b.x, b.w);
    ih = span_overlap(a.y, a.h, b.y, b.h);
    inter = iw * ih;
    uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
    if (uni == 0) return 1'b0;
    return inter * 256 > longint'(threshold) * uni;
  endfunction

  function automatic res_t predict_decision(req_t r);
    res_t o;
    gbs_pkg::box_t cur;
    if (r.fs) begin
      kept_num = 0;
      frame_pos = '0;
    end
    cur.x = r.x;
    cur.y = r.y;
    cur.w = r.w;
    cur.h = r.h;
    o.keep = 1'b1;
    o.full = 1'b0;
    for (int i = 0; i < kept_num; i++) begin
      if (overlaps_too_much(cur, kept_list[i])) o.keep = 1'b0;
    end
    if (o.keep) begin
      if (kept_num < MaxKept) begin
        kept_list[kept_num] = cur;
        kept_num++;
      end else begin
        o.full = 1'b1;
      end
    end
    o.idx = frame_pos;
    frame_pos = frame_pos + 16'd1;
    o.cnt = 7'(kept_num);
    return o;
  endfunction

  task automatic send_box(req_t r, bit has_res, res_t res);
    res_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    frame_start <= r.fs;
    box_x <= r.x;
    box_y <= r.y;
    box_width <= r.w;
    box_height <= r.h;
    p = predict_decision(r);
    if (has_res && p != res) begin
      $error("directed row: expected %h, predicted %h", res, p);
      errors++;
    end
    pending_results.insert(pending_results.size(), p);
    do @(posedge clk); while (in_stall);
    accepted++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3 * MaxKept + 10) @(negedge clk);
  endtask

  task automatic write_threshold(logic [8:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    threshold = v;
  endtask

  function automatic req_t random_box(bit clustered);
    req_t r;
    r.fs = ($urandom_range(39) == 0);
    if (clustered) begin
      r.x = 16'($urandom_range(600)) - 16'd300;
      r.y = 16'($urandom_range(600)) - 16'd300;
      r.w = 15'($urandom_range(400));
      r.h = 15'($urandom_range(400));
    end else begin
      r.x = 16'($urandom);
      r.y = 16'($urandom);
      r.w = 15'($urandom);
      r.h = 15'($urandom);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got, exp_res;
    if (!rst && out_valid && !out_stall) begin
      got = '{keep, item_index, kept_count, list_full};
      if (got.keep) kept_seen++;
      if (got.full) full_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (got.keep !== exp_res.keep) begin
          $error("keep: expected %0d, got %0d", exp_res.keep, got.keep);
          errors++;
        end
        if (got.idx !== exp_res.idx) begin
          $error("item_index: expected %0d, got %0d", exp_res.idx, got.idx);
          errors++;
        end
        if (got.cnt !== exp_res.cnt) begin
          $error("kept_count: expected %0d, got %0d", exp_res.cnt, got.cnt);
          errors++;
        end
        if (got.full !== exp_res.full) begin
          $error("list_full: expected %0d, got %0d", exp_res.full, got.full);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    row_t rows[$];
    req_t r;
    res_t none;
    int phase_idle[4];
    int phase_stall[4];
    phase_idle = '{0, 84, 0, 19};
    phase_stall = '{0, 0, 84, 19};
    none = '0;
    errors = 0;
    accepted = 0;
    kept_seen = 0;
    full_seen = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    frame_start = 1'b0;
    box_x = '0;
    box_y = '0;
    box_width = '0;
    box_height = '0;
    kept_num = 0;
    frame_pos = '0;
    threshold = gbs_pkg::IouThresholdReset;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    rows.insert(rows.size(), '{'{1'b1, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff}, 1'b1,
                               '{1'b1, 16'd0, 7'd1, 1'b0}});
    rows.insert(rows.size(), '{'{1'b0, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff}, 1'b1,
                               '{1'b0, 16'd1, 7'd1, 1'b0}});
    rows.insert(rows.size(), '{'{1'b0, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff}, 1'b0, none});
    rows.insert(rows.size(), '{'{1'b0, 16'd0, 16'd0, 15'd0, 15'd0}, 1'b0, none});
    rows.insert(rows.size(), '{'{1'b0, 16'd0, 16'd0, 15'd0, 15'd0}, 1'b0, none});
    rows.insert(rows.size(), '{'{1'b1, 16'd0, 16'd0, 15'd16, 15'd16}, 1'b1,
                               '{1'b1, 16'd0, 7'd1, 1'b0}});
    rows.insert(rows.size(), '{'{1'b0, 16'd16, 16'd0, 15'd16, 15'd16}, 1'b0, none});
    rows.insert(rows.size(), '{'{1'b0, 16'd4, 16'd0, 15'd16, 15'd16}, 1'b0, none});
    rows.insert(rows.size(), '{'{1'b0, 16'd8, 16'd0, 15'd16, 15'd16}, 1'b0, none});
    rows.insert(rows.size(), '{'{1'b0, 16'hfffc, 16'hfffc, 15'd24, 15'd24}, 1'b0, none});
    rows.insert(rows.size(), '{'{1'b0, 16'h7000, 16'h9000, 15'h0fff, 15'h0001}, 1'b0, none});
    foreach (rows[i]) send_box(rows[i].r, rows[i].has_res, rows[i].res);

    write_threshold(9'd256);
    for (int i = 0; i < 3; i++) begin
      r = '{1'b0, 16'd0, 16'd0, 15'd16, 15'd16};
      send_box(r, 1'b0, none);
    end
    write_threshold(9'd0);
    r = '{1'b1, 16'd0, 16'd0, 15'd16, 15'd16};
    send_box(r, 1'b0, none);
    r = '{1'b0, 16'd15, 16'd15, 15'd16, 15'd16};
    send_box(r, 1'b1, '{1'b0, 16'd1, 7'd1, 1'b0});
    write_threshold(9'h1ff);
    for (int i = 0; i < 68; i++) begin
      r = '{(i == 0), 16'(i * 64), 16'd0, 15'd32, 15'd32};
      send_box(r, 1'b0, none);
    end

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_threshold((ph == 3) ? 9'd115 : 9'($urandom_range(256)));
      send_idle_pct = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      for (int i = 0; i < NumRandom / 4; i++) begin
        r = random_box($urandom_range(9) != 0);
        send_box(r, 1'b0, none);
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();

    $display("Checked %0d boxes (%0d kept, %0d with the list full) over", accepted,
             kept_seen, full_seen);
    $display("several thresholds and idle/stall mixes.");
    if (errors == 0) begin
      $display("** greedy_box_suppression_unit: PASSED **");
    end else begin
      $display("** greedy_box_suppression_unit: FAILED **");
    end
    $finish;
  end
endmodule
